FILE: rtl/vpli_pkg.sv
// Shared types, codes and address helpers for the video port and line interrupt unit.
package vpli_pkg;

	localparam int unsigned VIDEO_MEM_BYTES_DEF  = 16384;
	localparam int unsigned COLOUR_MEM_BYTES_DEF = 64;
	localparam int unsigned LINES_PER_FRAME_DEF  = 262;
	localparam int unsigned ACTIVE_LINES_DEF     = 192;
	localparam int unsigned NUM_MODE_REGS        = 11;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [7:0] PORT_VCOUNT  = 8'h7E;
	localparam logic [7:0] PORT_HCOUNT  = 8'h7F;
	localparam logic [7:0] PORT_DATA    = 8'hBE;
	localparam logic [7:0] PORT_CONTROL = 8'hBF;

	localparam logic [1:0] CODE_VRAM_READ  = 2'd0;
	localparam logic [1:0] CODE_VRAM_WRITE = 2'd1;
	localparam logic [1:0] CODE_REG_WRITE  = 2'd2;
	localparam logic [1:0] CODE_CRAM_WRITE = 2'd3;

	localparam logic [3:0] REG_MODE0   = 4'd0;
	localparam logic [3:0] REG_MODE1   = 4'd1;
	localparam logic [3:0] REG_LINECNT = 4'd10;

	localparam int unsigned BIT_LINE_IRQ_EN  = 4;
	localparam int unsigned BIT_FRAME_IRQ_EN = 5;
	localparam int unsigned BIT_DISPLAY_EN   = 6;

	localparam logic [7:0] READ_OPEN_BUS = 8'hFF;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] port;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
		logic       draw_line;
		logic [8:0] line_number;
	} res_t;

	typedef struct packed {
		logic        vwe;
		logic        vre;
		logic [13:0] vaddr;
		logic [7:0]  wdata;
		logic        cwe;
		logic [5:0]  caddr;
	} mem_req_t;

	// Video memory index: address modulo n, n at least 1024, by binary restoring steps.
	function automatic logic [13:0] vid_index(input logic [13:0] a, input int unsigned n);
		logic [17:0] t;
		logic [17:0] lim;
		t = {4'b0, a};
		for (int k = 3; k >= 0; k--) begin
			lim = 18'(n << k);
			if (t >= lim)
				t = t - lim;
		end
		return t[13:0];
	endfunction

	// Colour memory index: low six address bits modulo n, n at least 32.
	function automatic logic [5:0] col_index(input logic [13:0] a, input int unsigned n);
		logic [6:0] t;
		logic [6:0] lim;
		t = {1'b0, a[5:0]};
		lim = 7'(n);
		if (t >= lim)
			t = t - lim;
		return t[5:0];
	endfunction

endpackage

FILE: rtl/vpli_mem.sv
// Video memory with registered read and colour memory, both single port.
module vpli_mem #(
	parameter int unsigned VIDEO_MEM_BYTES  = vpli_pkg::VIDEO_MEM_BYTES_DEF,
	parameter int unsigned COLOUR_MEM_BYTES = vpli_pkg::COLOUR_MEM_BYTES_DEF
) (
	input  logic               clk,
	input  vpli_pkg::mem_req_t mem_req,
	output logic [7:0]         rdata
);

	localparam int unsigned VA_W = $clog2(VIDEO_MEM_BYTES);
	localparam int unsigned CA_W = $clog2(COLOUR_MEM_BYTES);

	logic [7:0] vmem [VIDEO_MEM_BYTES];
	logic [7:0] cmem [COLOUR_MEM_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_req.vwe)
			vmem[mem_req.vaddr[VA_W-1:0]] <= mem_req.wdata;
		if (mem_req.vre)
			rdata_q <= vmem[mem_req.vaddr[VA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_req.cwe)
			cmem[mem_req.caddr[CA_W-1:0]] <= mem_req.wdata;
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/vpli_core.sv
// Port decode, access state, mode registers and line counter with next-state logic.
module vpli_core #(
	parameter int unsigned VIDEO_MEM_BYTES  = vpli_pkg::VIDEO_MEM_BYTES_DEF,
	parameter int unsigned COLOUR_MEM_BYTES = vpli_pkg::COLOUR_MEM_BYTES_DEF,
	parameter int unsigned LINES_PER_FRAME  = vpli_pkg::LINES_PER_FRAME_DEF,
	parameter int unsigned ACTIVE_LINES     = vpli_pkg::ACTIVE_LINES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  vpli_pkg::req_t     req,
	input  logic [7:0]         mem_rdata,
	output vpli_pkg::mem_req_t mem_req,
	output vpli_pkg::res_t     res
);

	localparam logic [8:0] ACTIVE = 9'(ACTIVE_LINES);
	localparam logic [8:0] LPF    = 9'(LINES_PER_FRAME);

	logic        pend_q, pend_n;
	logic [7:0]  latch_q, latch_n;
	logic [13:0] addr_q, addr_n;
	logic [1:0]  code_q, code_n;
	logic [7:0]  pf_q, pf_n;
	logic        pfmem_q, pfmem_n;
	logic        vblank_q, vblank_n;
	logic        irq_q, irq_n;
	logic [7:0]  ldc_q, ldc_n;
	logic [8:0]  vc_q, vc_n;
	logic [7:0]  regs_q [vpli_pkg::NUM_MODE_REGS];
	logic [7:0]  regs_n [vpli_pkg::NUM_MODE_REGS];
	logic [7:0]  pf_cur;
	logic [7:0]  rd;
	logic        draw;
	logic [3:0]  ridx;

	assign pf_cur = pfmem_q ? mem_rdata : pf_q;
	assign ridx   = req.value[3:0];

	always_comb begin
		pend_n   = pend_q;
		latch_n  = latch_q;
		addr_n   = addr_q;
		code_n   = code_q;
		pf_n     = pf_q;
		pfmem_n  = pfmem_q;
		vblank_n = vblank_q;
		irq_n    = irq_q;
		ldc_n    = ldc_q;
		vc_n     = vc_q;
		regs_n   = regs_q;
		rd       = 8'd0;
		draw     = 1'b0;
		mem_req  = '0;
		mem_req.vaddr = vpli_pkg::vid_index(addr_q, VIDEO_MEM_BYTES);
		mem_req.caddr = vpli_pkg::col_index(addr_q, COLOUR_MEM_BYTES);
		mem_req.wdata = req.value;
		unique case (req.mode)
			vpli_pkg::MODE_READ: begin
				unique case (req.port)
					vpli_pkg::PORT_VCOUNT: rd = vc_q[7:0];
					vpli_pkg::PORT_HCOUNT: rd = 8'd0;
					vpli_pkg::PORT_DATA: begin
						pend_n      = 1'b0;
						rd          = pf_cur;
						mem_req.vre = fire;
						pfmem_n     = 1'b1;
						addr_n      = addr_q + 14'd1;
					end
					vpli_pkg::PORT_CONTROL: begin
						rd       = {vblank_q, 7'd0};
						pend_n   = 1'b0;
						vblank_n = 1'b0;
						irq_n    = 1'b0;
					end
					default: rd = vpli_pkg::READ_OPEN_BUS;
				endcase
			end
			vpli_pkg::MODE_WRITE: begin
				if (req.port == vpli_pkg::PORT_DATA) begin
					pend_n = 1'b0;
					if (code_q == vpli_pkg::CODE_VRAM_WRITE ||
					    code_q == vpli_pkg::CODE_CRAM_WRITE) begin
						mem_req.vwe = fire && (code_q == vpli_pkg::CODE_VRAM_WRITE);
						mem_req.cwe = fire && (code_q == vpli_pkg::CODE_CRAM_WRITE);
						pf_n        = req.value;
						pfmem_n     = 1'b0;
						addr_n      = addr_q + 14'd1;
					end
				end else if (req.port == vpli_pkg::PORT_CONTROL) begin
					if (!pend_q) begin
						latch_n = req.value;
						pend_n  = 1'b1;
					end else begin
						pend_n = 1'b0;
						addr_n = {req.value[5:0], latch_q};
						code_n = req.value[7:6];
						if (code_n == vpli_pkg::CODE_VRAM_READ) begin
							mem_req.vaddr = vpli_pkg::vid_index(addr_n, VIDEO_MEM_BYTES);
							mem_req.vre   = fire;
							pfmem_n       = 1'b1;
							addr_n        = addr_n + 14'd1;
						end else if (code_n == vpli_pkg::CODE_REG_WRITE) begin
							if (ridx < 4'(vpli_pkg::NUM_MODE_REGS))
								regs_n[ridx] = latch_q;
						end
					end
				end
			end
			vpli_pkg::MODE_TICK: begin
				if (vc_q < ACTIVE) begin
					if (ldc_q == 8'd0) begin
						ldc_n = regs_q[vpli_pkg::REG_LINECNT];
						if (regs_q[vpli_pkg::REG_MODE0][vpli_pkg::BIT_LINE_IRQ_EN])
							irq_n = 1'b1;
					end else begin
						ldc_n = ldc_q - 8'd1;
					end
				end else begin
					ldc_n = regs_q[vpli_pkg::REG_LINECNT];
				end
				vc_n = vc_q + 9'd1;
				draw = (vc_n < ACTIVE) &&
				       regs_q[vpli_pkg::REG_MODE1][vpli_pkg::BIT_DISPLAY_EN];
				if (vc_n == ACTIVE &&
				    regs_q[vpli_pkg::REG_MODE1][vpli_pkg::BIT_FRAME_IRQ_EN]) begin
					vblank_n = 1'b1;
					irq_n    = 1'b1;
				end
				if (vc_n > LPF)
					vc_n = vc_n - LPF;
			end
			default: begin
			end
		endcase
		res.read_data   = rd;
		res.irq_level   = irq_n;
		res.draw_line   = draw;
		res.line_number = vc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			latch_q  <= 8'd0;
			addr_q   <= 14'd0;
			code_q   <= 2'd0;
			pf_q     <= 8'd0;
			pfmem_q  <= 1'b0;
			vblank_q <= 1'b0;
			irq_q    <= 1'b0;
			ldc_q    <= 8'd0;
			vc_q     <= 9'd0;
			for (int i = 0; i < vpli_pkg::NUM_MODE_REGS; i++)
				regs_q[i] <= 8'd0;
		end else if (fire) begin
			pend_q   <= pend_n;
			latch_q  <= latch_n;
			addr_q   <= addr_n;
			code_q   <= code_n;
			pf_q     <= pf_n;
			pfmem_q  <= pfmem_n;
			vblank_q <= vblank_n;
			irq_q    <= irq_n;
			ldc_q    <= ldc_n;
			vc_q     <= vc_n;
			regs_q   <= regs_n;
		end
	end

endmodule

FILE: rtl/video_port_and_line_interrupt_unit.sv
// Top level of the video port and line interrupt unit: request register, core, result register.
//
//   channel   handshake              payload
//   request   req_valid, req_stall   mode, port, value
//   result    res_valid, res_stall   read_data, irq_level, draw_line, line_number
//
// One request enters per cycle unless a stalled result blocks it; it is held in the request
// register, and its result is presented from the result register. The prefetch buffer refill
// reads the video memory port in the cycle the request is processed; its registered data is
// used by the next data read. Reset clears all control state; memories stay undefined.
// A stalled result holds the request register, which then stalls input.
module video_port_and_line_interrupt_unit #(
	parameter int unsigned VIDEO_MEM_BYTES  = vpli_pkg::VIDEO_MEM_BYTES_DEF,
	parameter int unsigned COLOUR_MEM_BYTES = vpli_pkg::COLOUR_MEM_BYTES_DEF,
	parameter int unsigned LINES_PER_FRAME  = vpli_pkg::LINES_PER_FRAME_DEF,
	parameter int unsigned ACTIVE_LINES     = vpli_pkg::ACTIVE_LINES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] mode,
	input  logic [7:0] port,
	input  logic [7:0] value,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] read_data,
	output logic       irq_level,
	output logic       draw_line,
	output logic [8:0] line_number
);

	vpli_pkg::req_t     req_s1;
	logic               valid_s1;
	vpli_pkg::res_t     res_q;
	logic               res_valid_q;
	vpli_pkg::res_t     res_n;
	vpli_pkg::mem_req_t mem_req;
	logic [7:0]         mem_rdata;
	logic               adv;

	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1.mode  <= mode;
			req_s1.port  <= port;
			req_s1.value <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_n;
	end

	vpli_core #(
		.VIDEO_MEM_BYTES  (VIDEO_MEM_BYTES),
		.COLOUR_MEM_BYTES (COLOUR_MEM_BYTES),
		.LINES_PER_FRAME  (LINES_PER_FRAME),
		.ACTIVE_LINES     (ACTIVE_LINES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.req       (req_s1),
		.mem_rdata (mem_rdata),
		.mem_req   (mem_req),
		.res       (res_n)
	);

	vpli_mem #(
		.VIDEO_MEM_BYTES  (VIDEO_MEM_BYTES),
		.COLOUR_MEM_BYTES (COLOUR_MEM_BYTES)
	) u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

	assign res_valid   = res_valid_q;
	assign read_data   = res_q.read_data;
	assign irq_level   = res_q.irq_level;
	assign draw_line   = res_q.draw_line;
	assign line_number = res_q.line_number;

	a_stall_only_on_blocked_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall))
		else $error("request stalled without a blocked result");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid)
		else $error("processed request produced no result");

	a_line_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (line_number <= 9'(LINES_PER_FRAME)))
		else $error("line counter beyond frame length");

	a_no_mem_access_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !(mem_req.vwe || mem_req.vre || mem_req.cwe))
		else $error("memory access without a processed request");

endmodule
